FILE: design/pump_telegram_framer_macros.svh
// assertion helpers for the framer modules, used by the byte emitter (ptf_back)
`ifndef PUMP_TELEGRAM_FRAMER_MACROS_SVH
`define PUMP_TELEGRAM_FRAMER_MACROS_SVH

// same-cycle implication
`define PTF_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("framer check failed");

// next-cycle implication
`define PTF_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("framer check failed");

`endif

FILE: design/ptf_pkg.sv
package ptf_pkg;

    localparam int PARAM_W = 10;
    localparam int VALUE_W = 20;

    localparam logic [1:0] REQ_QUERY  = 2'd0;
    localparam logic [1:0] REQ_WRITE3 = 2'd1;
    localparam logic [1:0] REQ_WRITE6 = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;

    localparam logic [PARAM_W-1:0] PARAM_MAX  = 10'd999;
    localparam logic [VALUE_W-1:0] VALUE3_MAX = 20'd999;
    localparam logic [VALUE_W-1:0] VALUE6_MAX = 20'd999999;

    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_ONE   = 8'h31;
    localparam logic [7:0] CHR_TWO   = 8'h32;
    localparam logic [7:0] CHR_THREE = 8'h33;
    localparam logic [7:0] CHR_SIX   = 8'h36;
    localparam logic [7:0] CHR_EQ    = 8'h3D;
    localparam logic [7:0] CHR_QMARK = 8'h3F;
    localparam logic [7:0] CHR_CR    = 8'h0D;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [PARAM_W-1:0] param_number;
        logic [VALUE_W-1:0] write_value;
    } req_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
    } resp_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] node_bcd;
        logic [11:0] param_bcd;
        logic [23:0] value_bcd;
    } job_t;

    // one double-dabble step: adjust digits, shift in one bit
    function automatic logic [23:0] ptf_dabble(input logic [23:0] bcd, input logic b);
        logic [23:0] adj;
        adj = bcd;
        for (int i = 0; i < 6; i++) begin
            if (adj[i*4 +: 4] >= 4'd5) begin
                adj[i*4 +: 4] = adj[i*4 +: 4] + 4'd3;
            end
        end
        return {adj[22:0], b};
    endfunction

    function automatic logic [11:0] ptf_bin8_bcd(input logic [7:0] v);
        logic [11:0] bcd;
        bcd = 12'd0;
        for (int i = 7; i >= 0; i--) begin
            for (int j = 0; j < 3; j++) begin
                if (bcd[j*4 +: 4] >= 4'd5) begin
                    bcd[j*4 +: 4] = bcd[j*4 +: 4] + 4'd3;
                end
            end
            bcd = {bcd[10:0], v[i]};
        end
        return bcd;
    endfunction

endpackage

FILE: design/ptf_front.sv
module ptf_front
    import ptf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] node_address,
    input  logic       s_valid,
    output logic       s_ready,
    input  req_t       s_data,
    output logic       push_valid,
    input  logic       push_ready,
    output job_t       push_job
);

    localparam int CONV_STEPS = VALUE_W / 2;
    localparam int CNT_W      = $clog2(CONV_STEPS);

    typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_HOLD} state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [1:0]         kind_reg, kind_next;
    logic [11:0]        node_reg, node_next;
    logic [VALUE_W-1:0] psh_reg, psh_next;
    logic [VALUE_W-1:0] vsh_reg, vsh_next;
    logic [23:0]        pbcd_reg, pbcd_next;
    logic [23:0]        vbcd_reg, vbcd_next;

    logic               accept;
    logic [PARAM_W-1:0] p_sat;
    logic [VALUE_W-1:0] v_sat;
    logic [23:0]        p_step, v_step;

    assign s_ready    = (state_reg == ST_IDLE) || (state_reg == ST_HOLD && push_ready);
    assign accept     = s_valid && s_ready;
    assign push_valid = (state_reg == ST_HOLD);
    assign push_job   = '{kind: kind_reg, node_bcd: node_reg,
                          param_bcd: pbcd_reg[11:0], value_bcd: vbcd_reg};

    always_comb begin
        p_sat = (s_data.param_number > PARAM_MAX) ? PARAM_MAX : s_data.param_number;
        v_sat = s_data.write_value;
        if (s_data.req_type == REQ_WRITE3 && s_data.write_value > VALUE3_MAX) begin
            v_sat = VALUE3_MAX;
        end else if (s_data.req_type == REQ_WRITE6 && s_data.write_value > VALUE6_MAX) begin
            v_sat = VALUE6_MAX;
        end
        p_step = ptf_dabble(ptf_dabble(pbcd_reg, psh_reg[VALUE_W-1]), psh_reg[VALUE_W-2]);
        v_step = ptf_dabble(ptf_dabble(vbcd_reg, vsh_reg[VALUE_W-1]), vsh_reg[VALUE_W-2]);
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        kind_next  = kind_reg;
        node_next  = node_reg;
        psh_next   = psh_reg;
        vsh_next   = vsh_reg;
        pbcd_next  = pbcd_reg;
        vbcd_next  = vbcd_reg;
        unique case (state_reg)
            ST_IDLE: begin
            end
            ST_CONV: begin
                pbcd_next = p_step;
                vbcd_next = v_step;
                psh_next  = psh_reg << 2;
                vsh_next  = vsh_reg << 2;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CONV_STEPS - 1)) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (push_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (accept && s_data.req_type != REQ_NONE) begin
            state_next = ST_CONV;
            cnt_next   = '0;
            kind_next  = s_data.req_type;
            node_next  = ptf_bin8_bcd(node_address);
            psh_next   = {{(VALUE_W-PARAM_W){1'b0}}, p_sat};
            vsh_next   = v_sat;
            pbcd_next  = '0;
            vbcd_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cnt_reg  <= cnt_next;
        kind_reg <= kind_next;
        node_reg <= node_next;
        psh_reg  <= psh_next;
        vsh_reg  <= vsh_next;
        pbcd_reg <= pbcd_next;
        vbcd_reg <= vbcd_next;
    end

endmodule

FILE: design/ptf_queue.sv
module ptf_queue
    import ptf_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  job_t in_job,
    output logic out_valid,
    input  logic out_ready,
    output job_t out_job
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_job   = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem[wr_ptr_reg] <= in_job;
        end
    end

endmodule

FILE: design/ptf_back.sv
`include "pump_telegram_framer_macros.svh"

module ptf_back
    import ptf_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  job_valid,
    output logic  job_pop,
    input  job_t  job,
    output logic  m_valid,
    input  logic  m_ready,
    output resp_t m_data
);

    logic        m_valid_reg, m_valid_next;
    resp_t       m_data_reg, m_data_next;
    logic [4:0]  idx_reg, idx_next;
    logic [7:0]  sum_reg, sum_next;

    logic        load, last;
    logic [4:0]  data_end, pos, ck;
    logic [7:0]  byte_val;
    logic [11:0] cks_bcd;

    function automatic logic [3:0] pick(input logic [23:0] bcd, input logic [2:0] sel);
        case (sel)
            3'd0:    pick = bcd[3:0];
            3'd1:    pick = bcd[7:4];
            3'd2:    pick = bcd[11:8];
            3'd3:    pick = bcd[15:12];
            3'd4:    pick = bcd[19:16];
            3'd5:    pick = bcd[23:20];
            default: pick = 4'd0;
        endcase
    endfunction

    function automatic logic [7:0] asc(input logic [3:0] d);
        return CHR_ZERO | {4'd0, d};
    endfunction

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign load    = job_valid && (!m_valid_reg || m_ready);
    assign job_pop = load && last;

    always_comb begin
        unique case (job.kind)
            REQ_QUERY:  data_end = 5'd12;
            REQ_WRITE3: data_end = 5'd13;
            default:    data_end = 5'd16;
        endcase
        pos     = idx_reg - 5'd10;
        ck      = idx_reg - data_end;
        cks_bcd = ptf_bin8_bcd(sum_reg);
        last    = (idx_reg == data_end + 5'd3);
        case (idx_reg)
            5'd0:    byte_val = asc(job.node_bcd[11:8]);
            5'd1:    byte_val = asc(job.node_bcd[7:4]);
            5'd2:    byte_val = asc(job.node_bcd[3:0]);
            5'd3:    byte_val = (job.kind == REQ_QUERY) ? CHR_ZERO : CHR_ONE;
            5'd4:    byte_val = CHR_ZERO;
            5'd5:    byte_val = asc(job.param_bcd[11:8]);
            5'd6:    byte_val = asc(job.param_bcd[7:4]);
            5'd7:    byte_val = asc(job.param_bcd[3:0]);
            5'd8:    byte_val = CHR_ZERO;
            5'd9: begin
                case (job.kind)
                    REQ_QUERY:  byte_val = CHR_TWO;
                    REQ_WRITE3: byte_val = CHR_THREE;
                    default:    byte_val = CHR_SIX;
                endcase
            end
            default: begin
                if (idx_reg < data_end) begin
                    case (job.kind)
                        REQ_QUERY:  byte_val = (pos == 5'd0) ? CHR_EQ : CHR_QMARK;
                        REQ_WRITE3: byte_val = asc(pick(job.value_bcd, 3'd2 - pos[2:0]));
                        default:    byte_val = asc(pick(job.value_bcd, 3'd5 - pos[2:0]));
                    endcase
                end else if (last) begin
                    byte_val = CHR_CR;
                end else begin
                    byte_val = asc(pick({12'd0, cks_bcd}, 3'd2 - ck[2:0]));
                end
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        idx_next     = idx_reg;
        sum_next     = sum_reg;
        if (load) begin
            m_valid_next = 1'b1;
            m_data_next  = '{tx_byte: byte_val, last_byte: last};
            idx_next     = last ? 5'd0 : idx_reg + 5'd1;
            if (idx_reg < data_end) begin
                sum_next = ((idx_reg == 5'd0) ? 8'd0 : sum_reg) + byte_val;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= 5'd0;
        end else begin
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
        end
        m_data_reg <= m_data_next;
        sum_reg    <= sum_next;
    end

    `PTF_ASSERT_IMP(a_cr_on_last, aclk, aresetn, m_valid_reg && m_data_reg.last_byte, m_data_reg.tx_byte == CHR_CR)
    `PTF_ASSERT_IMP(a_job_held, aclk, aresetn, idx_reg != 5'd0, job_valid)
    `PTF_ASSERT_IMP(a_idx_range, aclk, aresetn, 1'b1, idx_reg <= 5'd19)
    `PTF_ASSERT_NXT(a_idx_step, aclk, aresetn, load && !last, idx_reg == $past(idx_reg) + 5'd1)

endmodule

FILE: design/pump_telegram_framer.sv
// channel   ports                             moves
// s         s_valid s_ready s_data            request item in
// m         m_valid m_ready m_data            telegram byte item out
// cfg       cfg_valid cfg_ready cfg_data      node address write
//
// one byte leaves the output register per cycle while m_ready is high and a job
// is queued: a query is 16 bytes, a 3-digit write 17 and a 6-digit write 20;
// the byte emitter sets the rate; the front converts two bits per cycle
// reset clears the queue and output, node address returns to 1
// m_ready low holds the byte; the front keeps going until the queue is full
module pump_telegram_framer
    import ptf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  req_t       s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output resp_t      m_data
);

    logic [7:0] node_reg, node_next;
    logic       push_valid, push_ready, job_valid, job_pop;
    job_t       push_job, job;

    assign cfg_ready = 1'b1;

    always_comb begin
        node_next = node_reg;
        if (cfg_valid) begin
            node_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_reg <= 8'd1;
        end else begin
            node_reg <= node_next;
        end
    end

    ptf_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .node_address (node_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_job     (push_job)
    );

    ptf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_job    (push_job),
        .out_valid (job_valid),
        .out_ready (job_pop),
        .out_job   (job)
    );

    ptf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .job       (job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
